[hdl/dtf_pkg.sv]
// shared types and codes for the 3x3 deflate threshold filter
`default_nettype none

package dtf_pkg;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_THRESHOLD    = 2'd2,
    CFG_WIDE_MODE    = 2'd3
  } cfg_index_t;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic flush;
    logic row0;
    logic emit;
    logic col_ge1;
    logic col_eq1;
    logic col_last;
  } stage_ctrl_t;

  typedef struct packed {
    logic        last;
    logic        eof;
    logic        eor;
    logic [15:0] pixel;
  } result_t;

endpackage

`default_nettype wire

[hdl/deflate_3x3_threshold_filter.sv]
// top level of the streaming 3x3 deflate filter with threshold
`default_nettype none

// Raster-order pixels enter on the in_ stream (tuser = 0 for a sample, 1 for a flush tick)
// and filtered pixels leave on the out_ stream one row and one column behind. One item is
// accepted per clock unless the output stalls; the two line stores are RAMs with one write
// and one registered read per cycle, with a bypass for back-to-back access to the same
// column. An item is registered in s1 and its results in the output registers before out_
// offers them. An item at the last column of a later row yields two results if the width
// exceeds one; the second waits in a holding register and the item after it yields none,
// so the rate stays at one item per clock while out_tready is high. The input stalls only
// when out_tready is held low and the output registers are full. After the last row, one
// flush tick per column drives out the final row. Line stores are not cleared after reset.
module deflate_3x3_threshold_filter
  import dtf_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // pixel_in
  input  wire logic        in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,  // pixel_out
  output logic             out_tlast,  // end_of_frame
  output logic      [1:0]  out_tuser   // end_of_row, last
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int PW = PIXEL_BITS;
  localparam logic [14:0] MAXW = 15'(MAX_WIDTH);

  logic [12:0] frame_width_r;
  logic [15:0] frame_height_r;
  logic [15:0] threshold_r;
  logic        wide_mode_r;

  logic [AW-1:0] column_count_r;
  logic [AW-1:0] flush_count_r;
  logic [15:0]   row_count_r;

  logic              s1_valid_r;
  stage_ctrl_t       s1_ctrl_r;
  logic [AW-1:0]     s1_addr_r;
  logic [PW-1:0]     s1_pix_r;
  logic              s1_fwd_r;
  logic [PW-1:0]     fwd_upper_r;
  logic [PW-1:0]     fwd_middle_r;
  logic [PW-1:0]     win_r [6];

  logic    oa_valid_r;
  logic    ob_valid_r;
  result_t oa_r;
  result_t ob_r;

  logic [14:0]   wm1_wide;
  logic [AW-1:0] wm1;
  logic [15:0]   h_eff;
  logic [15:0]   thr_eff;
  logic          is_flush;
  logic          active;
  logic          accept;
  logic          load;
  logic [AW-1:0] col;
  logic          col_last;
  stage_ctrl_t   ctrl_nxt;
  logic [PW-1:0] pix_nxt;
  logic          fwd_nxt;

  logic [PW-1:0] up_q;
  logic [PW-1:0] mid_q;
  logic [PW-1:0] cur0;
  logic [PW-1:0] cur1;
  logic [PW-1:0] cur2;
  logic [PW-1:0] f1;
  logic [PW-1:0] f2;
  logic          s1_has_out;
  logic          s1_commit;
  logic          out_can_load;
  logic          out_xfer;
  logic          ram_we;
  result_t       first_res;
  result_t       second_res;

  function automatic logic [PW-1:0] filt(
    input logic [PW-1:0] l0, input logic [PW-1:0] l1, input logic [PW-1:0] l2,
    input logic [PW-1:0] c0, input logic [PW-1:0] c1, input logic [PW-1:0] c2,
    input logic [PW-1:0] r0, input logic [PW-1:0] r1, input logic [PW-1:0] r2,
    input logic [15:0] thr
  );
    logic [PW+2:0] s;
    logic [PW-1:0] mean;
    logic [PW-1:0] res;
    logic [15:0]   ctr16;
    logic [15:0]   lo16;
    s = {3'b000, l0} + {3'b000, c0} + {3'b000, r0} + {3'b000, l1}
      + {3'b000, r1} + {3'b000, l2} + {3'b000, c2} + {3'b000, r2};
    mean  = s[PW+2:3];
    res   = (mean < c1) ? mean : c1;
    ctr16 = 16'(c1);
    lo16  = (ctr16 > thr) ? (ctr16 - thr) : 16'd0;
    if (16'(res) < lo16) begin
      res = lo16[PW-1:0];
    end
    return res;
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 13'd4096;
      frame_height_r <= 16'd2;
      threshold_r    <= 16'hffff;
      wide_mode_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[12:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        CFG_THRESHOLD:    threshold_r    <= cfg_wdata;
        CFG_WIDE_MODE:    wide_mode_r    <= cfg_wdata[0];
      endcase
    end
  end

  always_comb begin
    if (frame_width_r == 13'd0) begin
      wm1_wide = 15'd0;
    end else if ({2'b00, frame_width_r} > MAXW) begin
      wm1_wide = MAXW - 15'd1;
    end else begin
      wm1_wide = {2'b00, frame_width_r} - 15'd1;
    end
  end
  assign wm1     = wm1_wide[AW-1:0];
  assign h_eff   = (frame_height_r == 16'd0) ? 16'd1 : frame_height_r;
  assign thr_eff = wide_mode_r ? threshold_r : {8'h00, threshold_r[7:0]};

  // input side
  assign is_flush = (in_tuser == KIND_FLUSH);
  assign active   = is_flush ? (row_count_r >= h_eff) : (row_count_r < h_eff);
  assign accept   = in_tvalid && in_tready;
  assign load     = accept && active;
  assign col      = is_flush ? flush_count_r : column_count_r;
  assign col_last = (col >= wm1);
  assign pix_nxt  = wide_mode_r ? in_tdata[PW-1:0] : PW'(in_tdata[7:0]);

  always_comb begin
    ctrl_nxt.flush    = is_flush;
    ctrl_nxt.row0     = !is_flush && (row_count_r == 16'd0);
    ctrl_nxt.emit     = is_flush || (row_count_r != 16'd0);
    ctrl_nxt.col_ge1  = (col != '0);
    ctrl_nxt.col_eq1  = (col == AW'(1));
    ctrl_nxt.col_last = col_last;
  end

  // the previous item writes this column in the same cycle
  assign fwd_nxt = s1_commit && !s1_ctrl_r.flush && (s1_addr_r == col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      flush_count_r  <= '0;
      row_count_r    <= '0;
    end else if (load) begin
      if (is_flush) begin
        if (col_last) begin
          flush_count_r  <= '0;
          column_count_r <= '0;
          row_count_r    <= '0;
        end else begin
          flush_count_r <= col + AW'(1);
        end
      end else begin
        if (col_last) begin
          column_count_r <= '0;
          row_count_r    <= row_count_r + 16'd1;
        end else begin
          column_count_r <= col + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (load) begin
      s1_valid_r <= 1'b1;
    end else if (s1_commit) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_ctrl_r    <= ctrl_nxt;
      s1_addr_r    <= col;
      s1_pix_r     <= pix_nxt;
      s1_fwd_r     <= fwd_nxt;
      fwd_upper_r  <= cur1;
      fwd_middle_r <= s1_pix_r;
    end
  end

  // line stores
  assign ram_we = s1_commit && !s1_ctrl_r.flush;

  dtf_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_upper_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (cur1),
    .re    (load),
    .raddr (col),
    .rdata (up_q)
  );

  dtf_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_middle_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (s1_pix_r),
    .re    (load),
    .raddr (col),
    .rdata (mid_q)
  );

  // window and filter
  always_comb begin
    if (s1_ctrl_r.row0) begin
      cur0 = s1_pix_r;
      cur1 = s1_pix_r;
    end else if (s1_fwd_r) begin
      cur0 = fwd_upper_r;
      cur1 = fwd_middle_r;
    end else begin
      cur0 = up_q;
      cur1 = mid_q;
    end
    cur2 = s1_ctrl_r.flush ? cur1 : s1_pix_r;
  end

  always_comb begin
    if (s1_ctrl_r.col_eq1) begin
      f1 = filt(win_r[0], win_r[1], win_r[2], win_r[0], win_r[1], win_r[2],
                cur0, cur1, cur2, thr_eff);
    end else begin
      f1 = filt(win_r[3], win_r[4], win_r[5], win_r[0], win_r[1], win_r[2],
                cur0, cur1, cur2, thr_eff);
    end
    if (s1_ctrl_r.col_ge1) begin
      f2 = filt(win_r[0], win_r[1], win_r[2], cur0, cur1, cur2,
                cur0, cur1, cur2, thr_eff);
    end else begin
      f2 = filt(cur0, cur1, cur2, cur0, cur1, cur2,
                cur0, cur1, cur2, thr_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_commit) begin
      win_r[3] <= win_r[0];
      win_r[4] <= win_r[1];
      win_r[5] <= win_r[2];
      win_r[0] <= cur0;
      win_r[1] <= cur1;
      win_r[2] <= cur2;
    end
  end

  // output side
  assign s1_has_out   = s1_ctrl_r.emit && (s1_ctrl_r.col_ge1 || s1_ctrl_r.col_last);
  assign out_xfer     = oa_valid_r && out_tready;
  assign out_can_load = !oa_valid_r || (out_xfer && !ob_valid_r);
  assign s1_commit    = s1_valid_r && (!s1_has_out || out_can_load);
  assign in_tready    = !s1_valid_r || s1_commit;

  always_comb begin
    second_res.last  = 1'b1;
    second_res.eof   = s1_ctrl_r.flush;
    second_res.eor   = 1'b1;
    second_res.pixel = 16'(f2);
    if (s1_ctrl_r.col_ge1) begin
      first_res.last  = !s1_ctrl_r.col_last;
      first_res.eof   = 1'b0;
      first_res.eor   = 1'b0;
      first_res.pixel = 16'(f1);
    end else begin
      first_res = second_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oa_valid_r <= 1'b0;
      ob_valid_r <= 1'b0;
    end else if (s1_commit && s1_has_out) begin
      oa_valid_r <= 1'b1;
      ob_valid_r <= s1_ctrl_r.col_ge1 && s1_ctrl_r.col_last;
    end else if (out_xfer) begin
      oa_valid_r <= ob_valid_r;
      ob_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_commit && s1_has_out) begin
      oa_r <= first_res;
      ob_r <= second_res;
    end else if (out_xfer && ob_valid_r) begin
      oa_r <= ob_r;
    end
  end

  assign out_tvalid = oa_valid_r;
  assign out_tdata  = oa_r.pixel;
  assign out_tlast  = oa_r.eof;
  assign out_tuser  = {oa_r.last, oa_r.eor};

endmodule

`default_nettype wire

[hdl/dtf_ram.sv]
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module dtf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/dtf_checker.sv]
// port-level checks of the deflate filter and their binding to the top level
`default_nettype none

module dtf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic [1:0]  out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

  // end of frame closes the row and the item
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0] && out_tuser[1])
    else $error("end of frame without end of row or last");

  // a non-final result is an interior pixel and its partner follows at once
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tuser[1] |=> out_tvalid && out_tuser[0] && out_tuser[1])
    else $error("second result of a pair missing");

  a_pair_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> !out_tuser[0] && !out_tlast)
    else $error("first result of a pair flagged as row end");

endmodule

bind deflate_3x3_threshold_filter dtf_checker u_dtf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire

[dv/deflate_3x3_threshold_filter_tb.sv]
// self-checking testbench for the streaming 3x3 deflate threshold filter
`timescale 1ns / 1ps

module deflate_3x3_threshold_filter_tb;
  import dtf_pkg::*;

  localparam int unsigned MAX_W       = 4096;
  localparam int unsigned RAND_ITEMS  = 1650;
  localparam int unsigned HOLD_CYCLES = 400;

  // one window column: [0] top, [1] centre, [2] bottom
  typedef logic [2:0][15:0] column_t;

  class deflate_checker;
    logic [15:0] older_row [MAX_W];
    logic [15:0] newer_row [MAX_W];
    column_t     col_prev;
    column_t     col_prev2;
    int unsigned x_pos;
    int unsigned y_pos;
    int unsigned drain_pos;
    logic [12:0] cfg_w;
    logic [15:0] cfg_h;
    logic [15:0] cfg_thr;
    logic        cfg_wide;
    result_t     pending_px [$];
    int unsigned errors;
    int unsigned n_seen;
    int unsigned n_used;
    int unsigned n_results;
    int unsigned frames_done;

    function new();
      foreach (older_row[i]) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      col_prev  = '0;
      col_prev2 = '0;
      x_pos     = 0;
      y_pos     = 0;
      drain_pos = 0;
      cfg_w     = 13'd4096;
      cfg_h     = 16'd2;
      cfg_thr   = 16'hFFFF;
      cfg_wide  = 1'b0;
    endfunction

    function int unsigned eff_width();
      if (cfg_w == 0) return 1;
      if (cfg_w > MAX_W) return MAX_W;
      return cfg_w;
    endfunction

    function int unsigned eff_height();
      return (cfg_h == 0) ? 1 : cfg_h;
    endfunction

    function bit in_drain();
      return y_pos >= eff_height();
    endfunction

    function void set_reg(cfg_index_t idx, logic [15:0] v);
      case (idx)
        CFG_FRAME_WIDTH:  cfg_w    = v[12:0];
        CFG_FRAME_HEIGHT: cfg_h    = v;
        CFG_THRESHOLD:    cfg_thr  = v;
        CFG_WIDE_MODE:    cfg_wide = v[0];
        default: ;
      endcase
    endfunction

    function logic [15:0] deflate_px(column_t lft, column_t ctr, column_t rgt);
      logic [18:0] sum;
      logic [15:0] mean;
      logic [15:0] thr;
      logic [15:0] res;
      logic [15:0] floor_v;
      sum = 19'(lft[0]) + ctr[0] + rgt[0] + lft[1] + rgt[1] + lft[2] + ctr[2] + rgt[2];
      mean = sum[18:3];
      thr = cfg_wide ? cfg_thr : {8'h00, cfg_thr[7:0]};
      res = (mean < ctr[1]) ? mean : ctr[1];
      floor_v = (ctr[1] > thr) ? ctr[1] - thr : 16'h0000;
      if (res < floor_v) res = floor_v;
      return res;
    endfunction

    function void shift_window(int unsigned c, column_t cur, int unsigned w, bit emit,
                               logic eof);
      result_t res [2];
      int      n;
      n = 0;
      if (emit) begin
        if (c >= 1) begin
          res[n] = '0;
          res[n].pixel = deflate_px((c == 1) ? col_prev : col_prev2, col_prev, cur);
          n++;
        end
        if (c >= w - 1) begin
          res[n] = '0;
          res[n].pixel = deflate_px((c >= 1) ? col_prev : cur, cur, cur);
          res[n].eor = 1'b1;
          res[n].eof = eof;
          n++;
        end
        if (n > 0) res[n - 1].last = 1'b1;
        for (int k = 0; k < n; k++) pending_px.push_back(res[k]);
      end
      col_prev2 = col_prev;
      col_prev  = cur;
    endfunction

    function void note_input(logic kind, logic [15:0] px);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      logic [15:0] v;
      column_t     cur;
      w = eff_width();
      h = eff_height();
      v = cfg_wide ? px : {8'h00, px[7:0]};
      n_seen++;
      if (kind == KIND_PIXEL) begin
        if (y_pos >= h) return;
        c = (x_pos >= MAX_W) ? MAX_W - 1 : x_pos;
        if (y_pos == 0) begin
          cur[0] = v;
          cur[1] = v;
          older_row[c] = v;
        end else begin
          cur[0] = older_row[c];
          cur[1] = newer_row[c];
          older_row[c] = cur[1];
        end
        cur[2] = v;
        newer_row[c] = v;
        shift_window(c, cur, w, y_pos != 0, 1'b0);
        if (c >= w - 1) begin
          x_pos = 0;
          y_pos = (y_pos + 1) & 16'hFFFF;
        end else begin
          x_pos = c + 1;
        end
      end else begin
        if (y_pos < h) return;
        c = (drain_pos >= MAX_W) ? MAX_W - 1 : drain_pos;
        cur[0] = older_row[c];
        cur[1] = newer_row[c];
        cur[2] = cur[1];
        shift_window(c, cur, w, 1'b1, 1'b1);
        if (c >= w - 1) begin
          drain_pos = 0;
          x_pos = 0;
          y_pos = 0;
          frames_done++;
        end else begin
          drain_pos = c + 1;
        end
      end
      n_used++;
    endfunction

    function void compare_field(string fname, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 200)
          $display("%0t: %s mismatch, expected %h actual %h", $time, fname, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      n_results++;
      if (pending_px.size() == 0) begin
        errors++;
        if (errors <= 200)
          $display("%0t: result with nothing expected, pixel_out %h", $time, got.pixel);
        return;
      end
      want = pending_px.pop_front();
      compare_field("pixel_out", want.pixel, got.pixel);
      compare_field("end_of_row", 16'(want.eor), 16'(got.eor));
      compare_field("end_of_frame", 16'(want.eof), 16'(got.eof));
      compare_field("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  cfg_index_t  cfg_index  = CFG_FRAME_WIDTH;
  logic [15:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;  // pixel_in
  logic        in_tuser   = KIND_PIXEL;  // kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;  // pixel_out
  logic        out_tlast;  // end_of_frame
  logic [1:0]  out_tuser;  // end_of_row, last

  int unsigned    idle_pct    = 0;
  bit             rx_hold_req = 1'b0;
  deflate_checker sb          = new;

  always #6 clk = ~clk;

  deflate_3x3_threshold_filter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  task automatic send_item(logic kind, logic [15:0] px);
    @(negedge clk);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(kind, px);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // drain outstanding results, then allow for items still in the pipe
  task automatic wait_idle();
    while (sb.pending_px.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [15:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_frame(int unsigned noise_pct, bit do_shrink);
    int unsigned start_frames;
    int unsigned used0;
    int unsigned shrink_at;
    logic [15:0] pix_base;
    logic [15:0] px;
    logic        kind;
    start_frames = sb.frames_done;
    used0        = sb.n_used;
    pix_base     = 16'($urandom);
    shrink_at    = 0;
    if (do_shrink)
      shrink_at = $urandom_range(1, sb.eff_width() * (sb.eff_height() + 1) - 1);
    while (sb.frames_done == start_frames) begin
      if (do_shrink && sb.n_used - used0 == shrink_at) begin
        // shrink mid-frame: counters may now sit beyond the new limits
        do_shrink = 1'b0;
        idle_input();
        wait_idle();
        if ($urandom_range(0, 1))
          write_reg(CFG_FRAME_WIDTH, 16'($urandom_range(1, sb.eff_width())));
        else
          write_reg(CFG_FRAME_HEIGHT, 16'($urandom_range(1, sb.eff_height())));
      end
      case ($urandom_range(0, 7))
        0:       px = 16'h0000;
        1:       px = 16'hFFFF;
        2, 3:    px = pix_base + 16'($urandom_range(0, 31));
        default: px = 16'($urandom);
      endcase
      if (sb.in_drain())
        kind = ($urandom_range(0, 99) < noise_pct) ? KIND_PIXEL : KIND_FLUSH;
      else
        kind = ($urandom_range(0, 99) < noise_pct) ? KIND_FLUSH : KIND_PIXEL;
      send_item(kind, px);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result({out_tuser[1], out_tlast, out_tuser[0], out_tdata});
  end

  initial begin : receiver
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  initial begin : watchdog
    #48_000_000;
    $display("[deflate_3x3_threshold_filter] ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned rand_start;
    int unsigned phase;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // 3x2, 8-bit: early flush, byte extremes, pixel during flush
    write_reg(CFG_FRAME_WIDTH, 16'd3);
    write_reg(CFG_FRAME_HEIGHT, 16'd2);
    write_reg(CFG_THRESHOLD, 16'h0010);
    write_reg(CFG_WIDE_MODE, 16'd0);
    send_item(KIND_FLUSH, 16'h1234);
    send_item(KIND_PIXEL, 16'h0000);
    send_item(KIND_PIXEL, 16'hFFFF);
    send_item(KIND_PIXEL, 16'h00FF);
    send_item(KIND_PIXEL, 16'hFF00);
    send_item(KIND_PIXEL, 16'h0080);
    send_item(KIND_PIXEL, 16'h007F);
    send_item(KIND_PIXEL, 16'h5555);
    send_item(KIND_FLUSH, 16'h0000);
    send_item(KIND_FLUSH, 16'hFFFF);
    send_item(KIND_FLUSH, 16'h0000);
    idle_input();
    wait_idle();

    // single column, zero height acts as one row, wide pixels
    write_reg(CFG_FRAME_WIDTH, 16'd1);
    write_reg(CFG_FRAME_HEIGHT, 16'd0);
    write_reg(CFG_THRESHOLD, 16'hFFFF);
    write_reg(CFG_WIDE_MODE, 16'd1);
    send_item(KIND_PIXEL, 16'hFFFF);
    send_item(KIND_FLUSH, 16'h0000);
    idle_input();
    wait_idle();

    // zero width acts as one column
    write_reg(CFG_FRAME_WIDTH, 16'd0);
    write_reg(CFG_FRAME_HEIGHT, 16'd3);
    write_reg(CFG_THRESHOLD, 16'h0000);
    send_item(KIND_PIXEL, 16'h8000);
    send_item(KIND_PIXEL, 16'h7FFF);
    send_item(KIND_PIXEL, 16'hFFFF);
    send_item(KIND_FLUSH, 16'h0000);
    idle_input();
    wait_idle();

    write_reg(CFG_FRAME_WIDTH, 16'd2);
    write_reg(CFG_FRAME_HEIGHT, 16'd2);
    write_reg(CFG_THRESHOLD, 16'h00FF);
    write_reg(CFG_WIDE_MODE, 16'd0);
    send_item(KIND_PIXEL, 16'h1234);
    send_item(KIND_PIXEL, 16'h00FF);
    send_item(KIND_PIXEL, 16'h0000);
    send_item(KIND_PIXEL, 16'hFF01);
    send_item(KIND_FLUSH, 16'h0000);
    send_item(KIND_FLUSH, 16'h0000);
    idle_input();
    wait_idle();

    // width register above the line size, then narrowed behind the column count
    idle_pct = 6;
    write_reg(CFG_FRAME_WIDTH, 16'h1FFF);
    write_reg(CFG_FRAME_HEIGHT, 16'd1);
    write_reg(CFG_THRESHOLD, 16'($urandom_range(0, 2000)));
    write_reg(CFG_WIDE_MODE, 16'd1);
    repeat (20) send_item(KIND_PIXEL, 16'($urandom));
    idle_input();
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 16'd8);
    run_frame(0, 1'b0);
    idle_input();
    wait_idle();

    // tallest height register, then lowered below the row count
    idle_pct = 0;
    write_reg(CFG_FRAME_WIDTH, 16'd1);
    write_reg(CFG_FRAME_HEIGHT, 16'hFFFF);
    repeat (12) send_item(KIND_PIXEL, 16'($urandom));
    idle_input();
    wait_idle();
    write_reg(CFG_FRAME_HEIGHT, 16'd5);
    run_frame(0, 1'b0);

    rand_start = sb.n_used;
    phase = 0;
    while (sb.n_used - rand_start < RAND_ITEMS) begin
      idle_input();
      wait_idle();
      if (sb.n_used - rand_start > RAND_ITEMS * 4 / 5) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 6;
          default: idle_pct = 25;
        endcase
      end
      if ($urandom_range(0, 3) != 0)
        write_reg(CFG_FRAME_WIDTH, 16'(($urandom_range(0, 7) == 0) ?
                  $urandom_range(17, 48) : $urandom_range(1, 12)));
      if ($urandom_range(0, 3) != 0)
        write_reg(CFG_FRAME_HEIGHT, 16'($urandom_range(1, 6)));
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_THRESHOLD, 16'h0000);
        1:       write_reg(CFG_THRESHOLD, 16'hFFFF);
        2:       write_reg(CFG_THRESHOLD, 16'($urandom_range(0, 40)));
        default: write_reg(CFG_THRESHOLD, 16'($urandom));
      endcase
      write_reg(CFG_WIDE_MODE, 16'($urandom_range(0, 1)));
      // long receiver hold while the sender keeps offering
      if (phase == 2) rx_hold_req = 1'b1;
      repeat ($urandom_range(1, 3)) run_frame(5, $urandom_range(0, 5) == 0);
      phase++;
    end

    idle_input();
    while (sb.pending_px.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d input transfers (%0d ignored), %0d frames, %0d results checked",
             sb.n_seen, sb.n_seen - sb.n_used, sb.frames_done, sb.n_results);
    $display("widths 0 to 4096+, heights 0 to 65535, both pixel modes, %0d mismatches",
             sb.errors);
    if (sb.errors == 0)
      $display("[deflate_3x3_threshold_filter] OK");
    else
      $display("[deflate_3x3_threshold_filter] ERROR");
    $finish;
  end

endmodule
